FILE: rtl/cursor_linked_list_engine_defines.svh
// Assertion macros for the cursor linked list engine.
// Depends on nothing; included by the top level.
`ifndef CURSOR_LINKED_LIST_ENGINE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_DEFINES_SVH
// property checked on every rising clock edge outside reset
`define CLLE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication checked on every rising clock edge outside reset
`define CLLE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`endif

FILE: rtl/clle_pkg.sv
// Shared types, command and status codes of the cursor linked list engine.
// Depends on nothing.
package clle_pkg;
    localparam int CapacityDefault = 32;
    localparam logic [3:0] CMD_INS_FRONT = 4'd0;
    localparam logic [3:0] CMD_INS_REAR  = 4'd1;
    localparam logic [3:0] CMD_RM_FRONT  = 4'd2;
    localparam logic [3:0] CMD_RM_REAR   = 4'd3;
    localparam logic [3:0] CMD_READ      = 4'd4;
    localparam logic [3:0] CMD_RM_CUR    = 4'd5;
    localparam logic [3:0] CMD_FIND_NUM  = 4'd6;
    localparam logic [3:0] CMD_FIND_NAME = 4'd7;
    localparam logic [3:0] CMD_CLEAR     = 4'd8;
    localparam logic [3:0] CMD_LIST      = 4'd9;
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOCUR    = 3'd4;

    // datapath operation selected by the controller
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LATCH  = 4'd1;  // take request, read record at cursor
    localparam logic [3:0] OP_INSERT = 4'd2;
    localparam logic [3:0] OP_UNLINK = 4'd3;
    localparam logic [3:0] OP_CLEAR  = 4'd4;
    localparam logic [3:0] OP_WSTART = 4'd5;  // start walk at front
    localparam logic [3:0] OP_WSTEP  = 4'd6;  // advance walk
    localparam logic [3:0] OP_HIT    = 4'd7;  // cursor to walk node

    typedef struct packed {
        logic [3:0] op;
        logic       rm_rear;
        logic       rm_cur;
        logic       ins_rear;
    } clle_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic cur_sent;
        logic walk_end;     // walk pointer on the sentinel
        logic walk_hit;     // record at walk pointer matches key
        logic walk_last;    // record at walk pointer is the rear
    } clle_stat_t;

    function automatic logic [71:0] trim_name(input logic [63:0] h, input logic [7:0] t);
        logic [71:0] r;
        logic        z;
        r = {t, h};
        z = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (r[8*i +: 8] == 8'd0) z = 1'b1;
            if (z) r[8*i +: 8] = 8'd0;
        end
        return r;
    endfunction
endpackage

FILE: rtl/clle_datapath.sv
// Datapath: record memory, link arrays, free map, cursor and walk pointer.
// Depends on clle_pkg.
module clle_datapath #(
    parameter int CAPACITY = clle_pkg::CapacityDefault
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  clle_pkg::clle_cmd_t    cmd,
    input  logic [3:0]             in_command,
    input  logic [31:0]            in_number,
    input  logic [63:0]            in_name_head,
    input  logic [7:0]             in_name_tail,
    output clle_pkg::clle_stat_t   stat,
    output logic [31:0]            rd_number,
    output logic [63:0]            rd_name_head,
    output logic [7:0]             rd_name_tail
);
    import clle_pkg::*;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] SENT = PW'(CAPACITY);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [31:0] mem_num [CAPACITY];
    logic [71:0] mem_name [CAPACITY];
    logic [PW-1:0] next_reg [CAPACITY];
    logic [PW-1:0] prev_reg [CAPACITY];
    logic [PW-1:0] head_reg, tail_reg;   // sentinel links: front and rear record
    logic [CAPACITY-1:0] used_reg;
    logic [PW-1:0] cursor_reg, walk_reg, free_reg;
    logic [PW:0] count_reg;
    logic [31:0] key_num_reg;
    logic [71:0] key_name_reg;
    logic        find_name_reg;
    logic [PW-1:0] tgt, tgt_next, tgt_prev;
    logic [PW-1:0] walk_link;
    logic [PW-1:0] walk_next;
    logic [PW-1:0] free_next;
    logic          found;

    // lowest free slot
    always_comb begin
        free_next = SENT;
        found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!used_reg[i] && !found) begin
                free_next = PW'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        if (cmd.rm_cur) tgt = cursor_reg;
        else if (cmd.rm_rear) tgt = tail_reg;
        else tgt = head_reg;
    end

    assign tgt_next = next_reg[tgt[SW-1:0]];
    assign tgt_prev = prev_reg[tgt[SW-1:0]];
    assign walk_link = next_reg[walk_reg[SW-1:0]];
    assign walk_next = (cmd.op == OP_WSTART) ? head_reg : walk_link;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= SENT;
            tail_reg <= SENT;
            used_reg <= '0;
            cursor_reg <= SENT;
            count_reg <= '0;
            walk_reg <= SENT;
            free_reg <= '0;
        end else begin
            free_reg <= free_next;
            case (cmd.op)
                OP_LATCH: begin
                    key_num_reg <= in_number;
                    key_name_reg <= trim_name(in_name_head, in_name_tail);
                    find_name_reg <= (in_command == CMD_FIND_NAME);
                end
                OP_INSERT: begin
                    mem_num[free_reg[SW-1:0]] <= key_num_reg;
                    mem_name[free_reg[SW-1:0]] <= key_name_reg;
                    used_reg[free_reg[SW-1:0]] <= 1'b1;
                    if (cmd.ins_rear) begin
                        if (tail_reg == SENT) head_reg <= free_reg;
                        else next_reg[tail_reg[SW-1:0]] <= free_reg;
                        tail_reg <= free_reg;
                        prev_reg[free_reg[SW-1:0]] <= tail_reg;
                        next_reg[free_reg[SW-1:0]] <= SENT;
                    end else begin
                        if (head_reg == SENT) tail_reg <= free_reg;
                        else prev_reg[head_reg[SW-1:0]] <= free_reg;
                        head_reg <= free_reg;
                        next_reg[free_reg[SW-1:0]] <= head_reg;
                        prev_reg[free_reg[SW-1:0]] <= SENT;
                    end
                    cursor_reg <= free_reg;
                    count_reg <= count_reg + 1'b1;
                end
                OP_UNLINK: begin
                    // a neighbour on the sentinel side updates the front or rear link
                    if (tgt_prev == SENT) head_reg <= tgt_next;
                    else next_reg[tgt_prev[SW-1:0]] <= tgt_next;
                    if (tgt_next == SENT) tail_reg <= tgt_prev;
                    else prev_reg[tgt_next[SW-1:0]] <= tgt_prev;
                    cursor_reg <= tgt_prev;
                    used_reg[tgt[SW-1:0]] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                end
                OP_CLEAR: begin
                    head_reg <= SENT;
                    tail_reg <= SENT;
                    used_reg <= '0;
                    cursor_reg <= SENT;
                    count_reg <= '0;
                end
                OP_WSTART, OP_WSTEP: walk_reg <= walk_next;
                OP_HIT: cursor_reg <= walk_reg;
                default: ;
            endcase
        end
    end

    // registered record read at the walk pointer or cursor
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WSTART || cmd.op == OP_WSTEP) begin
            rd_number <= mem_num[walk_next[SW-1:0]];
            {rd_name_tail, rd_name_head} <= mem_name[walk_next[SW-1:0]];
        end else if (cmd.op == OP_LATCH) begin
            rd_number <= mem_num[cursor_reg[SW-1:0]];
            {rd_name_tail, rd_name_head} <= mem_name[cursor_reg[SW-1:0]];
        end
    end

    always_comb begin
        stat.empty = (count_reg == '0);
        stat.full = (count_reg >= (PW+1)'(CAPACITY));
        stat.cur_sent = (cursor_reg == SENT);
        stat.walk_end = (walk_reg == SENT);
        stat.walk_last = (walk_reg != SENT) && (walk_link == SENT);
        stat.walk_hit = find_name_reg ? ({rd_name_tail, rd_name_head} == key_name_reg)
                                      : (rd_number == key_num_reg);
    end
endmodule

FILE: rtl/clle_ctrl.sv
// Controller: sequences each request and drives the result register.
// Depends on clle_pkg.
module clle_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [3:0]           in_command,
    input  clle_pkg::clle_stat_t stat,
    output clle_pkg::clle_cmd_t  cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2:0]           o_status,
    output logic                 o_has,
    output logic                 o_last
);
    import clle_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [3:0] cmd_reg;
    logic       mv_reg, mv_next;
    logic [2:0] st_reg, st_next;
    logic       has_reg, has_next, last_reg, last_next;
    logic       is_list;

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign o_status = st_reg;
    assign o_has = has_reg;
    assign o_last = last_reg;
    assign is_list = (cmd_reg == CMD_LIST);

    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg && !m_tready;
        st_next = st_reg;
        has_next = has_reg;
        last_next = last_reg;
        cmd = '0;
        cmd.rm_rear = (cmd_reg == CMD_RM_REAR);
        cmd.rm_cur = (cmd_reg == CMD_RM_CUR);
        cmd.ins_rear = (cmd_reg == CMD_INS_REAR);
        case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) begin
                cmd.op = OP_LATCH;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_OUT;
                st_next = ST_OK;
                has_next = 1'b0;
                last_next = 1'b1;
                case (cmd_reg)
                    CMD_INS_FRONT, CMD_INS_REAR:
                        if (stat.full) st_next = ST_FULL;
                        else cmd.op = OP_INSERT;
                    CMD_RM_FRONT, CMD_RM_REAR:
                        if (stat.empty) st_next = ST_EMPTY;
                        else cmd.op = OP_UNLINK;
                    CMD_RM_CUR:
                        if (stat.cur_sent) st_next = ST_NOCUR;
                        else cmd.op = OP_UNLINK;
                    CMD_READ:
                        if (stat.cur_sent) st_next = ST_NOCUR;
                        else has_next = 1'b1;
                    CMD_FIND_NUM, CMD_FIND_NAME, CMD_LIST:
                        if (stat.empty) st_next = ST_EMPTY;
                        else begin
                            cmd.op = OP_WSTART;
                            state_next = S_CHK;
                        end
                    CMD_CLEAR: cmd.op = OP_CLEAR;
                    default: ;
                endcase
            end
            S_CHK: begin
                // walk node data is registered; judge it
                if (stat.walk_end) begin
                    st_next = ST_NOTFOUND;
                    has_next = 1'b0;
                    last_next = 1'b1;
                    state_next = S_OUT;
                end else if (is_list) begin
                    st_next = ST_OK;
                    has_next = 1'b1;
                    last_next = stat.walk_last;
                    state_next = S_OUT;
                end else if (stat.walk_hit) begin
                    cmd.op = OP_HIT;
                    st_next = ST_OK;
                    has_next = 1'b1;
                    last_next = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.op = OP_WSTEP;
                end
            end
            S_OUT: begin
                mv_next = 1'b1;
                state_next = S_WALK;
            end
            S_WALK: if (!mv_reg || m_tready) begin
                if (is_list && !last_reg) begin
                    cmd.op = OP_WSTEP;
                    state_next = S_CHK;
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
        st_reg <= st_next;
        has_reg <= has_next;
        last_reg <= last_next;
        if (s_tvalid && s_tready) cmd_reg <= in_command;
    end
endmodule

FILE: rtl/cursor_linked_list_engine.sv
// Cursor linked list engine: bounded circular doubly linked list with cursor.
// Throughput: one request at a time; the next is taken once the last result of the
// previous request has been accepted.
// Reset (aresetn low, synchronous) empties the list, cursor on the sentinel.
`include "cursor_linked_list_engine_defines.svh"
module cursor_linked_list_engine #(
    parameter int CAPACITY = clle_pkg::CapacityDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[3:0], number[35:4], name_head[99:36], name_tail[107:100]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], has_record[3], record_number[35:4],
    // record_name_head[99:36], record_name_tail[107:100]
    output logic [111:0] m_tdata,
    output logic         m_tlast
);
    import clle_pkg::*;
    clle_cmd_t  cmd;
    clle_stat_t stat;
    logic [31:0] rd_number;
    logic [63:0] rd_name_head;
    logic [7:0]  rd_name_tail;
    logic [2:0]  o_status;
    logic        o_has;

    clle_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_command(s_tdata[3:0]), .stat(stat), .cmd(cmd), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .o_status(o_status), .o_has(o_has), .o_last(m_tlast)
    );

    clle_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_command(s_tdata[3:0]),
        .in_number(s_tdata[35:4]), .in_name_head(s_tdata[99:36]),
        .in_name_tail(s_tdata[107:100]), .stat(stat), .rd_number(rd_number),
        .rd_name_head(rd_name_head), .rd_name_tail(rd_name_tail)
    );

    assign m_tdata = {4'd0, o_has ? rd_name_tail : 8'd0, o_has ? rd_name_head : 64'd0,
                      o_has ? rd_number : 32'd0, o_has, o_status};

    `CLLE_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_tvalid, !s_tready, "accept while busy")
    `CLLE_ASSERT_IMP(a_has_ok, aclk, aresetn, m_tvalid && o_has, o_status == ST_OK, "bad status")
    `CLLE_ASSERT(a_full_empty, aclk, aresetn, !(stat.full && stat.empty), "full and empty")
endmodule

FILE: bench/tb_cursor_linked_list_engine.sv
// Testbench for cursor_linked_list_engine: directed table then random requests,
// checked against an in-bench model of the linked list. Depends on clle_pkg.
`timescale 1ns / 1ps
module tb_cursor_linked_list_engine;
    import clle_pkg::*;

    localparam int CAP = 32;
    localparam int SENT = CAP;
    localparam logic [3:0] CMD_SPARE = 4'd15;   // unused command code

    typedef struct packed {
        logic [7:0]  tail;
        logic [63:0] head;
        logic [31:0] number;
        logic [3:0]  command;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        has;
        logic [31:0] number;
        logic [63:0] head;
        logic [7:0]  tail;
        logic        last;
    } rec_t;

    typedef struct {
        req_t req;
        logic chk;      // typed-in expectation present
        logic [2:0] st;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         m_tlast;

    cursor_linked_list_engine #(.CAPACITY(CAP)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // list model
    logic [31:0] rec_num [CAP];
    logic [63:0] rec_head [CAP];
    logic [7:0]  rec_tail [CAP];
    int          nxt [CAP+1];
    int          prv [CAP+1];
    bit          slot_free [CAP];
    int          cur;
    int          count;

    rec_t        expected_records [$];
    int          mismatches = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          cycles = 0;
    int          rd_hold = 0;
    row_t        table_rows [$];
    logic [31:0] used_nums [$];
    logic [71:0] used_names [$];

    function automatic logic [71:0] clean_name(logic [63:0] h, logic [7:0] t);
        logic [71:0] r;
        bit z;
        r = {t, h};
        z = 0;
        for (int i = 0; i < 9; i++) begin
            if (r[8*i +: 8] == 0) z = 1;
            if (z) r[8*i +: 8] = 0;
        end
        return r;
    endfunction

    function automatic rec_t make_rec(logic [2:0] st, int slot, bit lst);
        rec_t r;
        r = '0;
        r.status = st;
        r.last = lst;
        if (slot >= 0) begin
            r.has = 1;
            r.number = rec_num[slot];
            r.head = rec_head[slot];
            r.tail = rec_tail[slot];
        end
        return r;
    endfunction

    task automatic list_reset();
        for (int i = 0; i < CAP; i++) slot_free[i] = 1;
        nxt[SENT] = SENT;
        prv[SENT] = SENT;
        cur = SENT;
        count = 0;
    endtask

    task automatic unlink(int p);
        nxt[prv[p]] = nxt[p];
        prv[nxt[p]] = prv[p];
        cur = prv[p];
        slot_free[p] = 1;
        count--;
    endtask

    // apply one request to the list model and queue its results
    task automatic predict_list_op(req_t r);
        int p, s, n;
        logic [71:0] key;
        bit hit;
        key = clean_name(r.head, r.tail);
        case (r.command)
            CMD_INS_FRONT, CMD_INS_REAR: begin
                if (count >= CAP) begin
                    expected_records.push_back(make_rec(ST_FULL, -1, 1));
                end else begin
                    for (s = 0; s < CAP; s++) if (slot_free[s]) break;
                    p = (r.command == CMD_INS_FRONT) ? SENT : prv[SENT];
                    rec_num[s] = r.number;
                    {rec_tail[s], rec_head[s]} = key;
                    slot_free[s] = 0;
                    n = nxt[p];
                    nxt[p] = s; prv[n] = s; prv[s] = p; nxt[s] = n;
                    cur = s;
                    count++;
                    expected_records.push_back(make_rec(ST_OK, -1, 1));
                end
            end
            CMD_RM_FRONT, CMD_RM_REAR: begin
                if (nxt[SENT] == SENT) begin
                    expected_records.push_back(make_rec(ST_EMPTY, -1, 1));
                end else begin
                    unlink(r.command == CMD_RM_FRONT ? nxt[SENT] : prv[SENT]);
                    expected_records.push_back(make_rec(ST_OK, -1, 1));
                end
            end
            CMD_READ:
                expected_records.push_back(cur == SENT ? make_rec(ST_NOCUR, -1, 1)
                                                       : make_rec(ST_OK, cur, 1));
            CMD_RM_CUR: begin
                if (cur == SENT) begin
                    expected_records.push_back(make_rec(ST_NOCUR, -1, 1));
                end else begin
                    unlink(cur);
                    expected_records.push_back(make_rec(ST_OK, -1, 1));
                end
            end
            CMD_FIND_NUM, CMD_FIND_NAME: begin
                if (nxt[SENT] == SENT) begin
                    expected_records.push_back(make_rec(ST_EMPTY, -1, 1));
                end else begin
                    hit = 0;
                    for (p = nxt[SENT]; p != SENT; p = nxt[p]) begin
                        if (r.command == CMD_FIND_NUM) hit = (rec_num[p] == r.number);
                        else hit = ({rec_tail[p], rec_head[p]} == key);
                        if (hit) break;
                    end
                    if (hit) begin
                        cur = p;
                        expected_records.push_back(make_rec(ST_OK, p, 1));
                    end else begin
                        expected_records.push_back(make_rec(ST_NOTFOUND, -1, 1));
                    end
                end
            end
            CMD_CLEAR: begin
                list_reset();
                expected_records.push_back(make_rec(ST_OK, -1, 1));
            end
            CMD_LIST: begin
                if (nxt[SENT] == SENT)
                    expected_records.push_back(make_rec(ST_EMPTY, -1, 1));
                else
                    for (p = nxt[SENT]; p != SENT; p = nxt[p])
                        expected_records.push_back(make_rec(ST_OK, p, nxt[p] == SENT));
            end
            default: expected_records.push_back(make_rec(ST_OK, -1, 1));
        endcase
    endtask

    // check every accepted result against the oldest expectation
    always @(posedge aclk) begin
        rec_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.status = m_tdata[2:0];
            got.has = m_tdata[3];
            got.number = m_tdata[35:4];
            got.head = m_tdata[99:36];
            got.tail = m_tdata[107:100];
            got.last = m_tlast;
            if (expected_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h last %b", m_tdata, m_tlast);
            end else begin
                want = expected_records.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp st %0d has %b num %h name %h%h last %b",
                                 want.status, want.has, want.number, want.tail,
                                 want.head, want.last);
                        $display("          got st %0d has %b num %h name %h%h last %b",
                                 got.status, got.has, got.number, got.tail,
                                 got.head, got.last);
                    end
                end
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
        cycles <= cycles + 1;
    end

    always @(posedge aclk) begin
        if (cycles > 2000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(req_t r);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= {4'd0, r.tail, r.head, r.number, r.command};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_list_op(r);
        @(negedge aclk);
    endtask

    function automatic logic [71:0] rand_name();
        logic [71:0] v;
        int len;
        v = 72'({$urandom, $urandom, $urandom});
        len = $urandom_range(9);
        if ($urandom_range(3) == 0) return v;       // raw bytes, maybe garbage after zero
        for (int i = 0; i < 9; i++) if (i >= len) v[8*i +: 8] = 0;
        return v;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int k;
        r.command = $urandom_range(99) < 3 ? 4'($urandom_range(15, 10))
                                           : 4'($urandom_range(9));
        k = $urandom_range(99);
        // bias towards inserts, keep clear rare
        if (k < 35) r.command = k[0] ? CMD_INS_REAR : CMD_INS_FRONT;
        if (r.command == CMD_CLEAR && $urandom_range(3) != 0) r.command = CMD_LIST;
        r.number = $urandom;
        {r.tail, r.head} = rand_name();
        if (r.command == CMD_INS_FRONT || r.command == CMD_INS_REAR) begin
            if ($urandom_range(2) == 0) r.number = $urandom_range(7);
            used_nums.push_back(r.number);
            used_names.push_back({r.tail, r.head});
        end else if (used_nums.size() > 0 && $urandom_range(2) != 0) begin
            k = $urandom_range(used_nums.size() - 1);
            r.number = used_nums[k];
            {r.tail, r.head} = used_names[k];
        end
        return r;
    endfunction

    task automatic add_row(logic [3:0] c, logic [31:0] n, logic [71:0] nm, bit chk,
                           logic [2:0] st);
        row_t w;
        w.req.command = c;
        w.req.number = n;
        {w.req.tail, w.req.head} = nm;
        w.chk = chk;
        w.st = st;
        table_rows.push_back(w);
    endtask

    initial begin
        int phase;
        req_t r;
        list_reset();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // special cases on the empty list, then extremes
        add_row(CMD_READ, 0, 0, 1, ST_NOCUR);
        add_row(CMD_RM_FRONT, 0, 0, 1, ST_EMPTY);
        add_row(CMD_RM_REAR, 0, 0, 1, ST_EMPTY);
        add_row(CMD_RM_CUR, 0, 0, 1, ST_NOCUR);
        add_row(CMD_FIND_NUM, 5, 0, 1, ST_EMPTY);
        add_row(CMD_FIND_NAME, 0, 72'h41, 1, ST_EMPTY);
        add_row(CMD_LIST, 0, 0, 1, ST_EMPTY);
        add_row(CMD_SPARE, 0, 0, 1, ST_OK);
        add_row(CMD_INS_FRONT, 32'h8000_0000, {72{1'b1}}, 1, ST_OK);
        add_row(CMD_INS_REAR, 32'h7FFF_FFFF, 72'hFF_00FF_FFFF, 1, ST_OK);
        add_row(CMD_INS_FRONT, 32'hFFFF_FFFF, 72'h0, 1, ST_OK);
        add_row(CMD_READ, 0, 0, 0, ST_OK);
        add_row(CMD_LIST, 0, 0, 0, ST_OK);
        add_row(CMD_FIND_NAME, 0, 72'hAA_00FF_FFFF, 0, ST_OK);
        add_row(CMD_FIND_NUM, 32'h8000_0000, 0, 0, ST_OK);
        add_row(CMD_FIND_NUM, 32'd12345, 0, 1, ST_NOTFOUND);
        add_row(CMD_RM_CUR, 0, 0, 0, ST_OK);
        add_row(CMD_READ, 0, 0, 0, ST_OK);
        add_row(CMD_RM_REAR, 0, 0, 0, ST_OK);
        add_row(CMD_RM_FRONT, 0, 0, 0, ST_OK);
        add_row(CMD_CLEAR, 0, 0, 1, ST_OK);
        add_row(CMD_READ, 0, 0, 1, ST_NOCUR);

        foreach (table_rows[i]) begin
            send_req(table_rows[i].req);
            if (table_rows[i].chk && expected_records[$].status !== table_rows[i].st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: model status %0d, table %0d", i,
                             expected_records[$].status, table_rows[i].st);
            end
        end

        // fill to capacity and overflow
        for (int i = 0; i < CAP + 2; i++) begin
            r = rand_req();
            r.command = i[0] ? CMD_INS_REAR : CMD_INS_FRONT;
            send_req(r);
        end
        r.command = CMD_LIST;
        send_req(r);

        for (phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 81 : 23) : 0;
            recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 81 : 23) : 0;
            for (int i = 0; i < 15; i++) send_req(rand_req());
        end
        s_tvalid <= 1'b0;
        recv_stall = 0;

        while (expected_records.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
